/* design/fspl_pkg.sv */
`default_nettype none
package fspl_pkg;

	localparam logic [3:0] PKT_LEN  = 4'd9;
	localparam logic [3:0] CNT_MAX  = 4'd15;
	localparam logic [7:0] HDR_RX   = 8'h3E;
	localparam logic [7:0] HDR_FMT  = 8'h06;
	localparam logic [7:0] HDR_TX   = 8'h31;

	localparam logic CMD_RX   = 1'b0;
	localparam logic CMD_POLL = 1'b1;

	localparam logic KIND_TX  = 1'b0;
	localparam logic KIND_RPT = 1'b1;

	localparam logic [1:0] REG_ADDR_A  = 2'd0;
	localparam logic [1:0] REG_ADDR_B  = 2'd1;
	localparam logic [1:0] REG_ADDR_C  = 2'd2;
	localparam logic [1:0] REG_TIMEOUT = 2'd3;

	localparam logic [1:0] WORD_HDR  = 2'd0;
	localparam logic [1:0] WORD_ADDR = 2'd1;
	localparam logic [1:0] WORD_FMT  = 2'd2;
	localparam logic [1:0] WORD_CRC  = 2'd3;

	localparam logic [7:0] CRC_TAPS [8] = '{8'h5e, 8'hbc, 8'h61, 8'hc2,
		8'h9d, 8'h23, 8'h46, 8'h8c};

	typedef struct packed {
		logic        accepted;
		logic [1:0]  sensor_index;
		logic [15:0] level;
	} fspl_rpt_t;

	typedef struct packed {
		logic        valid;
		logic [1:0]  sensor_index;
		logic [31:0] stamp;
	} fspl_upd_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  addr;
		logic [7:0]  crc;
		logic [2:0]  stale;
		logic        accepted;
		logic [1:0]  sensor_index;
		logic [15:0] level;
	} fspl_grp_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] x;
		logic [7:0] r;
		x = b ^ crc;
		r = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (x[i]) r = r ^ CRC_TAPS[i];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* design/fspl_item_if.sv */
`default_nettype none
interface fspl_item_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [7:0]  rx_byte;
	logic        rx_last;
	logic [31:0] now_ms;

	modport source (output valid, cmd, rx_byte, rx_last, now_ms, input ready);
	modport sink (input valid, cmd, rx_byte, rx_last, now_ms, output ready);
endinterface
`default_nettype wire

/* design/fspl_result_if.sv */
`default_nettype none
interface fspl_result_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  tx_byte;
	logic        tx_last;
	logic        accepted;
	logic [1:0]  sensor_index;
	logic [15:0] level_tenths;
	logic [2:0]  stale_mask;

	modport source (output valid, kind, tx_byte, tx_last, accepted, sensor_index,
		level_tenths, stale_mask, input ready);
	modport sink (input valid, kind, tx_byte, tx_last, accepted, sensor_index,
		level_tenths, stale_mask, output ready);
endinterface
`default_nettype wire

/* design/fspl_rx.sv */
`default_nettype none
module fspl_rx
	import fspl_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] rx_byte,
	input  wire logic       rx_last,
	input  wire logic [7:0] addr_a,
	input  wire logic [7:0] addr_b,
	input  wire logic [7:0] addr_c,
	output fspl_rpt_t       rpt
);

	logic [3:0] cnt_q;
	logic [7:0] crc_q;
	logic [7:0] pkt_q [PKT_LEN];
	logic       frame_ok;
	logic [7:0] addr;

	assign addr = pkt_q[1];

	// The current word is the check byte when it lands at the last position.
	assign frame_ok = (cnt_q == PKT_LEN - 4'd1) && (pkt_q[0] == HDR_RX)
		&& (pkt_q[2] == HDR_FMT) && (rx_byte == crc_q);

	always_comb begin
		rpt = '0;
		if (frame_ok) begin
			if (addr == addr_a) begin
				rpt.accepted = 1'b1;
				rpt.sensor_index = 2'd0;
			end else if (addr == addr_b) begin
				rpt.accepted = 1'b1;
				rpt.sensor_index = 2'd1;
			end else if (addr == addr_c) begin
				rpt.accepted = 1'b1;
				rpt.sensor_index = 2'd2;
			end
			if (rpt.accepted) rpt.level = {pkt_q[5], pkt_q[4]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			crc_q <= '0;
		end else if (step) begin
			if (rx_last) begin
				cnt_q <= '0;
				crc_q <= '0;
			end else begin
				if (cnt_q < PKT_LEN - 4'd1) crc_q <= crc8_step(crc_q, rx_byte);
				if (cnt_q != CNT_MAX) cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && (cnt_q < PKT_LEN)) pkt_q[cnt_q] <= rx_byte;
	end

endmodule
`default_nettype wire

/* design/fspl_poll.sv */
`default_nettype none
module fspl_poll
	import fspl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        poll,
	input  wire fspl_upd_t   upd,
	input  wire logic [31:0] now_ms,
	input  wire logic [15:0] timeout,
	input  wire logic [7:0]  addr_a,
	input  wire logic [7:0]  addr_b,
	input  wire logic [7:0]  addr_c,
	output logic [7:0]       req_addr,
	output logic [7:0]       req_crc,
	output logic [2:0]       stale
);

	logic [31:0] last_q [3];
	logic [1:0]  idx_q;
	logic [1:0]  idx;
	logic [31:0] age [3];

	assign idx = (idx_q == 2'd3) ? 2'd0 : idx_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			age[i] = now_ms - last_q[i];
			stale[i] = age[i] > {16'd0, timeout};
		end
	end

	always_comb begin
		case (idx)
			2'd1:    req_addr = addr_b;
			2'd2:    req_addr = addr_c;
			default: req_addr = addr_a;
		endcase
	end

	assign req_crc = crc8_step(crc8_step(crc8_step(8'h00, HDR_TX), req_addr), HDR_FMT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			for (int i = 0; i < 3; i++) last_q[i] <= '0;
		end else begin
			if (poll) idx_q <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
			if (upd.valid) last_q[upd.sensor_index] <= upd.stamp;
		end
	end

endmodule
`default_nettype wire

/* design/fspl_out_reg.sv */
`default_nettype none
module fspl_out_reg
	import fspl_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  load,
	input  wire fspl_grp_t ld,
	output logic       free,
	fspl_result_if.source res
);

	logic      valid_q;
	logic [1:0] cnt_q;
	fspl_grp_t grp_q;
	logic      fire;
	logic      done;

	assign fire = valid_q && res.ready;
	assign done = fire && ((grp_q.kind == KIND_RPT) || (cnt_q == WORD_CRC));
	assign free = !valid_q || done;

	assign res.valid = valid_q;
	assign res.kind = grp_q.kind;
	assign res.tx_last = (grp_q.kind == KIND_TX) && (cnt_q == WORD_CRC);
	assign res.accepted = grp_q.accepted;
	assign res.sensor_index = grp_q.sensor_index;
	assign res.level_tenths = grp_q.level;
	assign res.stale_mask = grp_q.stale;

	always_comb begin
		if (grp_q.kind == KIND_RPT) begin
			res.tx_byte = 8'h00;
		end else begin
			case (cnt_q)
				WORD_HDR:  res.tx_byte = HDR_TX;
				WORD_ADDR: res.tx_byte = grp_q.addr;
				WORD_FMT:  res.tx_byte = HDR_FMT;
				default:   res.tx_byte = grp_q.crc;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			cnt_q <= '0;
		end else if (done) begin
			valid_q <= 1'b0;
		end else if (fire) begin
			cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) grp_q <= ld;
	end

	a_rpt_single: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && (grp_q.kind == KIND_RPT)) |-> (cnt_q == WORD_HDR))
		else $error("report word held with nonzero word count");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!valid_q || done))
		else $error("new group loaded over an unfinished one");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !load) |=> !valid_q)
		else $error("output still valid after its last word was taken");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !res.ready) |=> (valid_q && $stable(cnt_q)))
		else $error("word position moved while stalled");

endmodule
`default_nettype wire

/* design/fuel_sensor_poll_link.sv */
`default_nettype none
// Channel  Role    Words per item               Fields
// item     sink    one                          cmd, rx_byte, rx_last, now_ms
// result   source  none, one report, four bytes kind, tx_byte, tx_last, accepted,
//                                               sensor_index, level_tenths, stale_mask
//
// An item is registered on entry and worked out from that register once it can advance.
// A closing byte yields one report word.
// A poll tick yields four request words, one per cycle while result is ready, from the output register.
// A byte that closes no packet leaves the entry register even while the output register
// waits; a tick or closing byte stays there until the output register frees, stalling input.
// Reset clears the packet state, answer times, poll position and valid flags, and loads the default settings.
module fuel_sensor_poll_link
	import fspl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	fspl_item_if.sink        item,
	fspl_result_if.source    result,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	logic        valid_s1;
	logic        cmd_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic [31:0] now_s1;

	logic [7:0]  addr_a_q;
	logic [7:0]  addr_b_q;
	logic [7:0]  addr_c_q;
	logic [15:0] timeout_q;

	logic        out_free;
	logic        needs_out;
	logic        adv;
	logic        load;
	fspl_rpt_t   rpt;
	fspl_upd_t   upd;
	fspl_grp_t   grp;
	logic [7:0]  req_addr;
	logic [7:0]  req_crc;
	logic [2:0]  stale;

	assign needs_out = (cmd_s1 == CMD_POLL) || last_s1;
	assign adv = valid_s1 && (!needs_out || out_free);
	assign load = adv && needs_out;
	assign item.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			cmd_s1 <= item.cmd;
			byte_s1 <= item.rx_byte;
			last_s1 <= item.rx_last;
			now_s1 <= item.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_a_q <= 8'd85;
			addr_b_q <= 8'd86;
			addr_c_q <= 8'd87;
			timeout_q <= 16'd5000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ADDR_A:  addr_a_q <= cfg_data[7:0];
				REG_ADDR_B:  addr_b_q <= cfg_data[7:0];
				REG_ADDR_C:  addr_c_q <= cfg_data[7:0];
				REG_TIMEOUT: timeout_q <= cfg_data;
			endcase
		end
	end

	fspl_rx u_rx (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv && (cmd_s1 == CMD_RX)),
		.rx_byte (byte_s1),
		.rx_last (last_s1),
		.addr_a  (addr_a_q),
		.addr_b  (addr_b_q),
		.addr_c  (addr_c_q),
		.rpt     (rpt)
	);

	assign upd.valid = adv && (cmd_s1 == CMD_RX) && last_s1 && rpt.accepted;
	assign upd.sensor_index = rpt.sensor_index;
	assign upd.stamp = now_s1;

	fspl_poll u_poll (
		.clk      (clk),
		.arst_n   (arst_n),
		.poll     (adv && (cmd_s1 == CMD_POLL)),
		.upd      (upd),
		.now_ms   (now_s1),
		.timeout  (timeout_q),
		.addr_a   (addr_a_q),
		.addr_b   (addr_b_q),
		.addr_c   (addr_c_q),
		.req_addr (req_addr),
		.req_crc  (req_crc),
		.stale    (stale)
	);

	always_comb begin
		grp = '0;
		if (cmd_s1 == CMD_POLL) begin
			grp.kind = KIND_TX;
			grp.addr = req_addr;
			grp.crc = req_crc;
			grp.stale = stale;
		end else begin
			grp.kind = KIND_RPT;
			grp.accepted = rpt.accepted;
			grp.sensor_index = rpt.sensor_index;
			grp.level = rpt.level;
		end
	end

	fspl_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.ld     (grp),
		.free   (out_free),
		.res    (result)
	);

endmodule
`default_nettype wire

/* verif/fspl_word_checker.sv */
`default_nettype none
module fspl_word_checker
	import fspl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	fspl_item_if             item_bus,
	fspl_result_if           result_bus,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output int               mismatch_total,
	output int               words_pending
);

	typedef struct packed {
		logic        kind;
		logic [7:0]  tx_byte;
		logic        tx_last;
		logic        accepted;
		logic [1:0]  sensor_index;
		logic [15:0] level_tenths;
		logic [2:0]  stale_mask;
	} link_word_t;

	link_word_t  due_words [$];
	link_word_t  want;
	link_word_t  got;
	logic [7:0]  sensor_addr [3];
	logic [15:0] stale_after;
	logic [3:0]  rx_count;
	logic [7:0]  rx_crc;
	logic [7:0]  rx_bytes [9];
	logic [31:0] answered_at [3];
	logic [1:0]  poll_slot;
	int          mismatches = 0;

	function automatic logic [7:0] maxim_crc8(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
		end
		return c;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_val,
		input logic [31:0] act_val);
		if (act_val !== exp_val) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
			mismatches++;
		end
	endtask

	task automatic work_out_item(input logic cmd, input logic [7:0] b, input logic last,
		input logic [31:0] now);
		link_word_t  w;
		logic [2:0]  stale;
		logic [1:0]  slot;
		logic [7:0]  req [4];
		logic [31:0] age;
		logic        ok;
		logic [1:0]  which;
		logic [15:0] level;
		w = '0;
		if (cmd == CMD_POLL) begin
			stale = '0;
			for (int i = 0; i < 3; i++) begin
				age = now - answered_at[i];
				if (age > {16'h0000, stale_after}) stale[i] = 1'b1;
			end
			slot = (poll_slot == 2'd3) ? 2'd0 : poll_slot;
			req[0] = HDR_TX;
			req[1] = sensor_addr[slot];
			req[2] = HDR_FMT;
			req[3] = maxim_crc8(maxim_crc8(maxim_crc8(8'h00, req[0]), req[1]), req[2]);
			poll_slot = (slot == 2'd2) ? 2'd0 : slot + 2'd1;
			for (int k = 0; k < 4; k++) begin
				w.kind = KIND_TX;
				w.tx_byte = req[k];
				w.tx_last = (k == 3);
				w.stale_mask = stale;
				due_words.push_back(w);
			end
		end else begin
			if (rx_count < PKT_LEN) rx_bytes[rx_count] = b;
			if (rx_count < PKT_LEN - 4'd1) rx_crc = maxim_crc8(rx_crc, b);
			if (rx_count < CNT_MAX) rx_count = rx_count + 4'd1;
			if (last) begin
				ok = (rx_count == PKT_LEN) && (rx_bytes[0] == HDR_RX) &&
					(rx_bytes[2] == HDR_FMT) && (rx_bytes[8] == rx_crc);
				which = 2'd0;
				level = 16'h0000;
				if (ok) begin
					if (rx_bytes[1] == sensor_addr[0]) which = 2'd0;
					else if (rx_bytes[1] == sensor_addr[1]) which = 2'd1;
					else if (rx_bytes[1] == sensor_addr[2]) which = 2'd2;
					else ok = 1'b0;
				end
				if (ok) begin
					level = {rx_bytes[5], rx_bytes[4]};
					answered_at[which] = now;
				end else begin
					which = 2'd0;
				end
				rx_count = 4'd0;
				rx_crc = 8'h00;
				w.kind = KIND_RPT;
				w.accepted = ok;
				w.sensor_index = which;
				w.level_tenths = level;
				due_words.push_back(w);
			end
		end
	endtask

	// Output words are checked before the item of the same edge is modeled,
	// since a word can never leave in the cycle its item enters.
	always @(posedge clk) begin
		if (!arst_n) begin
			sensor_addr[0] = 8'd85;
			sensor_addr[1] = 8'd86;
			sensor_addr[2] = 8'd87;
			stale_after = 16'd5000;
			rx_count = 4'd0;
			rx_crc = 8'h00;
			poll_slot = 2'd0;
			for (int i = 0; i < 9; i++) rx_bytes[i] = 8'h00;
			for (int i = 0; i < 3; i++) answered_at[i] = 32'h0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ADDR_A: sensor_addr[0] = cfg_data[7:0];
					REG_ADDR_B: sensor_addr[1] = cfg_data[7:0];
					REG_ADDR_C: sensor_addr[2] = cfg_data[7:0];
					REG_TIMEOUT: stale_after = cfg_data;
					default: ;
				endcase
			end
			if (result_bus.valid && result_bus.ready) begin
				got.kind = result_bus.kind;
				got.tx_byte = result_bus.tx_byte;
				got.tx_last = result_bus.tx_last;
				got.accepted = result_bus.accepted;
				got.sensor_index = result_bus.sensor_index;
				got.level_tenths = result_bus.level_tenths;
				got.stale_mask = result_bus.stale_mask;
				if (due_words.size() == 0) begin
					$display("%0t: word with nothing expected, expected none, actual %h",
						$time, got);
					mismatches++;
				end else begin
					want = due_words.pop_front();
					check_field("kind", 32'(want.kind), 32'(got.kind));
					check_field("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
					check_field("tx_last", 32'(want.tx_last), 32'(got.tx_last));
					check_field("accepted", 32'(want.accepted), 32'(got.accepted));
					check_field("sensor_index", 32'(want.sensor_index),
						32'(got.sensor_index));
					check_field("level_tenths", 32'(want.level_tenths),
						32'(got.level_tenths));
					check_field("stale_mask", 32'(want.stale_mask), 32'(got.stale_mask));
				end
			end
			if (item_bus.valid && item_bus.ready) begin
				work_out_item(item_bus.cmd, item_bus.rx_byte, item_bus.rx_last,
					item_bus.now_ms);
			end
		end
		mismatch_total <= mismatches;
		words_pending <= due_words.size();
	end

endmodule
`default_nettype wire

/* verif/testbench.sv */
`default_nettype none
module testbench;
	import fspl_pkg::*;

	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef enum logic [1:0] {PKT_GOOD, PKT_BAD_HDR, PKT_BAD_FMT, PKT_BAD_CRC} pkt_flaw_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	fspl_item_if   item_bus ();
	fspl_result_if result_bus ();

	int          mismatch_total;
	int          words_pending;
	int          send_idle_pct = 22;
	int          recv_idle_pct = 88;
	int          squeezes_asked = 0;
	int          squeezes_served = 0;
	int          hold_left = 0;
	int          quiet_cycles = 0;
	int          items_sent = 0;
	logic        time_jitter = 1'b0;
	logic [31:0] clock_ms = 32'h0;
	logic [7:0]  addr_cfg [3];

	fuel_sensor_poll_link i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_bus),
		.result    (result_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	fspl_word_checker i_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_bus       (item_bus),
		.result_bus     (result_bus),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_total (mismatch_total),
		.words_pending  (words_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		result_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (squeezes_served != squeezes_asked) begin
				squeezes_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("fuel_sensor_poll_link regression: fail");
			$finish;
		end
	end

	function automatic logic [7:0] dallas_crc8(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
		end
		return c;
	endfunction

	task automatic send_item(input logic c, input logic [7:0] b, input logic last);
		int pick;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_bus.valid <= 1'b0;
			@(negedge clk);
		end
		if (time_jitter) begin
			pick = $urandom_range(99);
			if (pick < 85) clock_ms = clock_ms + 32'($urandom_range(2500));
			else if (pick < 95) clock_ms = clock_ms + 32'($urandom_range(80000));
			else clock_ms = $urandom;
		end
		item_bus.valid <= 1'b1;
		item_bus.cmd <= c;
		item_bus.rx_byte <= b;
		item_bus.rx_last <= last;
		item_bus.now_ms <= clock_ms;
		@(posedge clk);
		while (!item_bus.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_packet(input logic [7:0] addr, input logic [15:0] level, input int len,
		input pkt_flaw_t flaw);
		logic [7:0] pkt [20];
		logic [7:0] crc;
		for (int i = 0; i < 20; i++) pkt[i] = 8'($urandom_range(255));
		pkt[0] = (flaw == PKT_BAD_HDR) ? (HDR_RX ^ 8'($urandom_range(1, 255))) : HDR_RX;
		pkt[1] = addr;
		pkt[2] = (flaw == PKT_BAD_FMT) ? (HDR_FMT ^ 8'($urandom_range(1, 255))) : HDR_FMT;
		pkt[4] = level[7:0];
		pkt[5] = level[15:8];
		crc = 8'h00;
		for (int i = 0; i < 8; i++) crc = dallas_crc8(crc, pkt[i]);
		pkt[8] = (flaw == PKT_BAD_CRC) ? (crc ^ 8'($urandom_range(1, 255))) : crc;
		for (int i = 0; i < len; i++) send_item(CMD_RX, pkt[i], i == len - 1);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
	endtask

	task automatic apply_settings(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
		input logic [15:0] tmo);
		write_reg(REG_ADDR_A, {8'($urandom_range(255)), a});
		write_reg(REG_ADDR_B, {8'($urandom_range(255)), b});
		write_reg(REG_ADDR_C, {8'($urandom_range(255)), c});
		write_reg(REG_TIMEOUT, tmo);
		@(negedge clk);
		cfg_we <= 1'b0;
		addr_cfg[0] = a;
		addr_cfg[1] = b;
		addr_cfg[2] = c;
	endtask

	task automatic drain();
		@(negedge clk);
		item_bus.valid <= 1'b0;
		@(posedge clk);
		while (words_pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_traffic(input int count);
		int          start;
		int          pick;
		logic [7:0]  stray;
		logic [15:0] level;
		start = items_sent;
		while (items_sent - start < count) begin
			pick = $urandom_range(99);
			level = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'h0000)
				: 16'($urandom_range(65535));
			if (pick < 50) begin
				send_packet(addr_cfg[$urandom_range(2)], level, 9, PKT_GOOD);
			end else if (pick < 70) begin
				send_item(CMD_POLL, 8'($urandom_range(255)), 1'($urandom_range(1)));
			end else if (pick < 75) begin
				send_packet(addr_cfg[$urandom_range(2)], level, 9, PKT_BAD_HDR);
			end else if (pick < 80) begin
				send_packet(addr_cfg[$urandom_range(2)], level, 9, PKT_BAD_FMT);
			end else if (pick < 85) begin
				send_packet(addr_cfg[$urandom_range(2)], level, 9, PKT_BAD_CRC);
			end else if (pick < 89) begin
				send_packet(addr_cfg[$urandom_range(2)], level, $urandom_range(1, 8), PKT_GOOD);
			end else if (pick < 93) begin
				send_packet(addr_cfg[$urandom_range(2)], level, $urandom_range(10, 20), PKT_GOOD);
			end else if (pick < 97) begin
				stray = 8'($urandom_range(255));
				while (stray == addr_cfg[0] || stray == addr_cfg[1] || stray == addr_cfg[2])
					stray = 8'($urandom_range(255));
				send_packet(stray, level, 9, PKT_GOOD);
			end else begin
				repeat ($urandom_range(1, 3))
					send_item(CMD_RX, 8'($urandom_range(255)), 1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ADDR_A;
		cfg_data = 16'h0000;
		item_bus.valid = 1'b0;
		item_bus.cmd = CMD_RX;
		item_bus.rx_byte = 8'h00;
		item_bus.rx_last = 1'b0;
		item_bus.now_ms = 32'h0;
		addr_cfg[0] = 8'd85;
		addr_cfg[1] = 8'd86;
		addr_cfg[2] = 8'd87;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// An answer exactly one timeout old is still fresh; one millisecond later it is stale.
		clock_ms = 32'h0001_0000;
		send_packet(addr_cfg[0], 16'hFFFF, 9, PKT_GOOD);
		clock_ms = clock_ms + 32'd5000;
		send_item(CMD_POLL, 8'h00, 1'b0);
		clock_ms = clock_ms + 32'd1;
		send_item(CMD_POLL, 8'hFF, 1'b1);
		send_item(CMD_POLL, 8'h5A, 1'b0);
		send_item(CMD_POLL, 8'hA5, 1'b1);
		send_packet(addr_cfg[2], 16'h0000, 9, PKT_GOOD);
		send_item(CMD_RX, HDR_RX, 1'b1);
		clock_ms = 32'hFFFF_FFFF;
		send_item(CMD_POLL, 8'h00, 1'b0);
		clock_ms = 32'h0;
		send_item(CMD_POLL, 8'hFF, 1'b0);

		drain();
		apply_settings(8'h00, 8'hFF, 8'h00, 16'h0000);
		time_jitter = 1'b1;
		random_traffic(85);

		drain();
		send_idle_pct = 88;
		recv_idle_pct = 22;
		apply_settings(8'h44, 8'h44, 8'hFF, 16'hFFFF);
		random_traffic(85);

		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
			16'($urandom_range(1000, 8000)));
		squeezes_asked++;
		random_traffic(90);

		drain();
		if (mismatch_total == 0)
			$display("fuel_sensor_poll_link regression: pass");
		else
			$display("fuel_sensor_poll_link regression: fail");
		$finish;
	end

endmodule
`default_nettype wire
